/* sv/glyph_run_rectangle_renderer_defines.svh */
// ----------------------------------------------------------------------------
// Glyph run rectangle renderer: assertion macros
// Shared concurrent check forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef GLYPH_RUN_RECTANGLE_RENDERER_DEFINES_SVH
`define GLYPH_RUN_RECTANGLE_RENDERER_DEFINES_SVH

// same-cycle implication
`define GRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph renderer check failed");

// next-cycle implication
`define GRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph renderer check failed");

`endif

/* sv/grr_pkg.sv */
// ----------------------------------------------------------------------------
// grr_pkg
// Types, glyph ROM, microprogram and helpers of the glyph run renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 7;
    localparam int ROM_ROWS     = 7;
    localparam int NUM_GLYPHS   = 3;
    localparam int PEN_STEP     = GLYPH_WIDTH + 1;

    localparam int COL_W = $clog2(GLYPH_WIDTH + 1);
    localparam int ROW_W = $clog2(GLYPH_HEIGHT + 1);

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_P = 8'h50;

    typedef enum logic [1:0] {
        GLYPH_A    = 2'd0,
        GLYPH_M    = 2'd1,
        GLYPH_P    = 2'd2,
        GLYPH_NONE = 2'd3
    } glyph_t;

    localparam logic [7:0] GLYPH_ROM [NUM_GLYPHS][ROM_ROWS] = '{
        '{8'h0E, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h11},
        '{8'h11, 8'h1B, 8'h15, 8'h15, 8'h11, 8'h11, 8'h11},
        '{8'h1E, 8'h11, 8'h11, 8'h1E, 8'h10, 8'h10, 8'h10}
    };

    typedef enum logic [1:0] {
        CFG_PIXEL_SCALE = 2'd0,
        CFG_LIT_COLOR   = 2'd1,
        CFG_UNLIT_COLOR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        first_char;
        logic [15:0] start_x;
        logic [15:0] start_y;
    } in_word_t;

    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [7:0]  rect_height;
        logic [15:0] rect_color;
        logic        bad_char;
        logic        last_of_char;
    } out_word_t;

    // ---- microcode ----
    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_IN    = 3'd2,
        C_ABORTED  = 3'd3,
        C_BAD      = 3'd4,
        C_COL_MORE = 3'd5,
        C_ROW_MORE = 3'd6
    } cond_t;

    localparam int UC_DEPTH = 7;
    localparam int STEP_W   = $clog2(UC_DEPTH);

    localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_SKIP  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_CHECK = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_RECT  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_ROW   = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_PEN   = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_ERR   = STEP_W'(6);

    typedef struct packed {
        logic              load;
        logic              emit_rect;
        logic              emit_err;
        logic              row_next;
        logic              pen_adv;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // load rect err row pen  cond  target
    localparam ucode_t UCODE [UC_DEPTH] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, C_NO_IN,    STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_ABORTED,  STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, C_BAD,      STEP_ERR},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, C_COL_MORE, STEP_RECT},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, C_ROW_MORE, STEP_RECT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, C_ALWAYS,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, C_ALWAYS,   STEP_WAIT}
    };

    // gated control from sequencer to datapath
    typedef struct packed {
        logic load;
        logic emit_rect;
        logic emit_err;
        logic row_next;
        logic pen_adv;
    } ctrl_t;

    // datapath flags tested by jumps and by the emit hold
    typedef struct packed {
        logic aborted;
        logic bad;
        logic col_more;
        logic row_more;
        logic out_busy;
    } stat_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        case (code)
            CHAR_A:  g = GLYPH_A;
            CHAR_M:  g = GLYPH_M;
            CHAR_P:  g = GLYPH_P;
            default: g = GLYPH_NONE;
        endcase
        return g;
    endfunction

    // pixel row, column 0 in bit 0; rows past the ROM read clear
    function automatic logic [GLYPH_WIDTH-1:0] glyph_pixels(input glyph_t g,
                                                           input logic [ROW_W-1:0] row);
        logic [7:0]             bits;
        logic [GLYPH_WIDTH-1:0] pix;
        bits = 8'h00;
        for (int gi = 0; gi < NUM_GLYPHS; gi++) begin
            for (int r = 0; r < ROM_ROWS; r++) begin
                if (g == glyph_t'(gi) && row == ROW_W'(r)) begin
                    bits = GLYPH_ROM[gi][r];
                end
            end
        end
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            pix[c] = bits[GLYPH_WIDTH-1-c];
        end
        return pix;
    endfunction

    function automatic logic pixel_at(input logic [GLYPH_WIDTH-1:0] pix,
                                      input logic [COL_W-1:0] col);
        logic lit;
        lit = 1'b0;
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            if (col == COL_W'(c)) begin
                lit = pix[c];
            end
        end
        return lit;
    endfunction

    // length of the run of equal pixels that starts at col
    function automatic logic [COL_W-1:0] run_length(input logic [GLYPH_WIDTH-1:0] pix,
                                                    input logic [COL_W-1:0] col);
        logic             lit;
        logic             going;
        logic [COL_W-1:0] run;
        lit   = pixel_at(pix, col);
        going = 1'b1;
        run   = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            if (COL_W'(c) >= col && going) begin
                if (pix[c] == lit) begin
                    run = run + COL_W'(1);
                end else begin
                    going = 1'b0;
                end
            end
        end
        return run;
    endfunction

endpackage

`default_nettype wire

/* sv/grr_sequencer.sv */
// ----------------------------------------------------------------------------
// grr_sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_sequencer (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  grr_pkg::stat_t    stat,
    output grr_pkg::ctrl_t    ctrl
);

    logic [grr_pkg::STEP_W-1:0] step_reg;
    logic [grr_pkg::STEP_W-1:0] step_next;
    grr_pkg::ucode_t            uc;
    logic                       hold;
    logic                       jump;

    assign uc = grr_pkg::UCODE[step_reg];

    // an emitting step waits for the output register to free up
    assign hold = (uc.emit_rect || uc.emit_err) && stat.out_busy;

    always_comb
    begin
        case (uc.cond)
            grr_pkg::C_NONE:     jump = 1'b0;
            grr_pkg::C_ALWAYS:   jump = 1'b1;
            grr_pkg::C_NO_IN:    jump = !in_valid;
            grr_pkg::C_ABORTED:  jump = stat.aborted;
            grr_pkg::C_BAD:      jump = stat.bad;
            grr_pkg::C_COL_MORE: jump = stat.col_more;
            grr_pkg::C_ROW_MORE: jump = stat.row_more;
            default:             jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = uc.target;
        end
        else
        begin
            step_next = step_reg + grr_pkg::STEP_W'(1);
        end
    end

    always_comb
    begin
        in_stall       = !uc.load;
        ctrl.load      = uc.load && in_valid;
        ctrl.emit_rect = uc.emit_rect && !stat.out_busy;
        ctrl.emit_err  = uc.emit_err && !stat.out_busy;
        ctrl.row_next  = uc.row_next;
        ctrl.pen_adv   = uc.pen_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= grr_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* sv/grr_datapath.sv */
// ----------------------------------------------------------------------------
// grr_datapath
// Config registers, pen and run walk state, rectangle math, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "glyph_run_rectangle_renderer_defines.svh"

module grr_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_index,
    input  wire  [15:0]          cfg_data,
    input  grr_pkg::in_word_t    in_word,
    input  grr_pkg::ctrl_t       ctrl,
    output grr_pkg::stat_t       stat,
    output logic                 out_valid,
    input  wire                  out_stall,
    output grr_pkg::out_word_t   out_word
);

    localparam int COL_W = grr_pkg::COL_W;
    localparam int ROW_W = grr_pkg::ROW_W;

    // control state
    logic [7:0]          scale_reg, scale_next;
    logic [15:0]         lit_reg, lit_next;
    logic [15:0]         unlit_reg, unlit_next;
    logic [15:0]         pen_reg, pen_next;
    logic                aborted_reg, aborted_next;
    logic                out_valid_reg, out_valid_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    // payload
    logic                bad_reg, bad_next;
    grr_pkg::glyph_t     glyph_reg, glyph_next;
    logic [15:0]         x_acc_reg, x_acc_next;
    logic [15:0]         y_acc_reg, y_acc_next;
    grr_pkg::out_word_t  out_word_reg, out_word_next;

    logic [grr_pkg::GLYPH_WIDTH-1:0] pix;
    logic                            lit;
    logic [COL_W-1:0]                run;
    logic [COL_W-1:0]                col_end;
    logic [15:0]                     width;
    logic [15:0]                     pen_eff;
    logic                            col_more;
    logic                            row_more;
    grr_pkg::glyph_t                 glyph_in;

    assign pix      = grr_pkg::glyph_pixels(glyph_reg, row_reg);
    assign lit      = grr_pkg::pixel_at(pix, col_reg);
    assign run      = grr_pkg::run_length(pix, col_reg);
    assign col_end  = col_reg + run;
    assign width    = 16'(run) * 16'(scale_reg);
    assign col_more = col_end < COL_W'(grr_pkg::GLYPH_WIDTH);
    assign row_more = row_reg < ROW_W'(grr_pkg::GLYPH_HEIGHT - 1);
    assign pen_eff  = in_word.first_char ? in_word.start_x : pen_reg;
    assign glyph_in = grr_pkg::glyph_lookup(in_word.char_code);

    always_comb
    begin
        stat.aborted  = aborted_reg;
        stat.bad      = bad_reg;
        stat.col_more = col_more;
        stat.row_more = row_more;
        stat.out_busy = out_valid_reg && out_stall;
    end

    always_comb
    begin
        scale_next     = scale_reg;
        lit_next       = lit_reg;
        unlit_next     = unlit_reg;
        pen_next       = pen_reg;
        aborted_next   = aborted_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bad_next       = bad_reg;
        glyph_next     = glyph_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            case (cfg_index)
                grr_pkg::CFG_PIXEL_SCALE: scale_next = cfg_data[7:0];
                grr_pkg::CFG_LIT_COLOR:   lit_next   = cfg_data;
                grr_pkg::CFG_UNLIT_COLOR: unlit_next = cfg_data;
                default:                  ;
            endcase
        end

        if (ctrl.load)
        begin
            pen_next     = pen_eff;
            aborted_next = in_word.first_char ? 1'b0 : aborted_reg;
            glyph_next   = glyph_in;
            bad_next     = (glyph_in == grr_pkg::GLYPH_NONE) || (scale_reg == 8'd0);
            x_acc_next   = pen_eff;
            y_acc_next   = in_word.start_y;
            col_next     = '0;
            row_next     = '0;
        end

        if (ctrl.emit_rect)
        begin
            out_valid_next             = 1'b1;
            out_word_next.rect_x       = x_acc_reg;
            out_word_next.rect_y       = y_acc_reg;
            out_word_next.rect_width   = width;
            out_word_next.rect_height  = scale_reg;
            out_word_next.rect_color   = lit ? lit_reg : unlit_reg;
            out_word_next.bad_char     = 1'b0;
            out_word_next.last_of_char = !col_more && !row_more;
            x_acc_next                 = x_acc_reg + width;
            col_next                   = col_end;
        end

        if (ctrl.emit_err)
        begin
            out_valid_next             = 1'b1;
            out_word_next              = '0;
            out_word_next.bad_char     = 1'b1;
            out_word_next.last_of_char = 1'b1;
            aborted_next               = 1'b1;
        end

        if (ctrl.row_next)
        begin
            row_next   = row_reg + ROW_W'(1);
            col_next   = '0;
            x_acc_next = pen_reg;
            y_acc_next = y_acc_reg + 16'(scale_reg);
        end

        if (ctrl.pen_adv)
        begin
            pen_next = pen_reg + 16'(grr_pkg::PEN_STEP) * 16'(scale_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= 8'd1;
            lit_reg       <= 16'hFFFF;
            unlit_reg     <= 16'h0000;
            pen_reg       <= 16'h0000;
            aborted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            scale_reg     <= scale_next;
            lit_reg       <= lit_next;
            unlit_reg     <= unlit_next;
            pen_reg       <= pen_next;
            aborted_reg   <= aborted_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bad_reg      <= bad_next;
        glyph_reg    <= glyph_next;
        x_acc_reg    <= x_acc_next;
        y_acc_reg    <= y_acc_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // column sits one past the glyph between the last run and the row turn
    `GRR_ASSERT_IMP(a_col_in_glyph, clk, rst_n, 1'b1, col_reg <= COL_W'(grr_pkg::GLYPH_WIDTH))
    `GRR_ASSERT_IMP(a_rect_nonempty, clk, rst_n, out_valid_reg && !out_word_reg.bad_char,
                    out_word_reg.rect_width != 16'd0 && out_word_reg.rect_height != 8'd0)
    `GRR_ASSERT_NXT(a_err_aborts, clk, rst_n, ctrl.emit_err,
                    aborted_reg && out_valid_reg && out_word_reg.bad_char
                    && out_word_reg.last_of_char)
    `GRR_ASSERT_IMP(a_no_emit_busy, clk, rst_n, out_valid_reg && out_stall,
                    !ctrl.emit_rect && !ctrl.emit_err)

endmodule

`default_nettype wire

/* sv/glyph_run_rectangle_renderer.sv */
// ----------------------------------------------------------------------------
// glyph_run_rectangle_renderer
// Draws A, M and P from a 5x7 font as filled rectangles, one per pixel run.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes one character word.
//   The block takes a new word only while its sequencer sits in the wait step.
//   Output channel (out_valid / out_stall / out_word) gives one rectangle word
//   per run of equal pixels in a glyph row, left column first, top row first;
//   last_of_char marks the final word of a character.
//   Config port (cfg_we / cfg_index / cfg_data) writes scale and colors;
//   write only while idle. Unused indexes are ignored.
//   With no output stall the block gives one rectangle per cycle within a row.
//   After accept it passes the skip and check steps before the first
//   rectangle; each row ends in a row-turn step and each character in a pen
//   step. An unknown character or zero scale gives one error word from the
//   error step after the check step; a character of an aborted text is dropped
//   at the skip step. The step rate is set by the microprogram walk.
//   A stalled output holds its word; the sequencer waits on the emitting step.
//   Reset: scale 1, lit 0xFFFF, unlit 0, pen 0, no text aborted, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_run_rectangle_renderer (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_index,
    input  wire  [15:0]          cfg_data,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  grr_pkg::in_word_t    in_word,
    output logic                 out_valid,
    input  wire                  out_stall,
    output grr_pkg::out_word_t   out_word
);

    grr_pkg::ctrl_t ctrl;
    grr_pkg::stat_t stat;

    grr_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    grr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire
